// ----- design/ckd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ckd_pkg: shared types, constants and helpers of the coherent demodulator
// Widths, register codes, the sine ROM contents and saturating helpers.
// ----------------------------------------------------------------------------
package ckd_pkg;

	localparam int SAMPLE_WIDTH     = 16;
	localparam int PHASE_WIDTH      = 32;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int ACC_WIDTH        = 48;

	localparam int ROM_ADDR_W = $clog2(SINE_TABLE_DEPTH);
	localparam int SINE_W     = 16;
	localparam int PROD_W     = SAMPLE_WIDTH + SINE_W;
	localparam int METRIC_W   = 64;
	localparam int COUNT_W    = 16;
	localparam int THR_W      = 48;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	// keying modes
	localparam logic [1:0] MODE_ASK = 2'd0;
	localparam logic [1:0] MODE_PSK = 2'd1;
	localparam logic [1:0] MODE_FSK = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPB      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INC_ONE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INC_TWO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ASK_THR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ONES_THR = 3'd5;

	// polynomial sine coefficients, Q30
	localparam logic [63:0] POLY_A1 = 64'd1686629713;
	localparam logic [63:0] POLY_A3 = 64'd691038763;
	localparam logic [63:0] POLY_A5 = 64'd78150874;
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] AMP_MAX = 64'd32767;

	typedef struct packed {
		logic [1:0]                    mode;
		logic [COUNT_W-1:0]            samples_per_bit;
		logic [PHASE_WIDTH-1:0]        phase_inc_one;
		logic [PHASE_WIDTH-1:0]        phase_inc_two;
		logic signed [THR_W-1:0]       ask_threshold;
		logic [COUNT_W-1:0]            ones_threshold;
	} cfg_t;

	// position of a sample within its bit period
	typedef struct packed {
		logic first;
		logic last;
	} tag_t;

	typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] turn;
		logic [63:0] quad;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] s;
		logic [63:0] amp;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			turn = (64'(k) << 32) / SINE_TABLE_DEPTH;
			quad = (turn >> 30) & 64'd3;
			x    = turn & (Q30_ONE - 64'd1);
			if (quad[0])
				x = Q30_ONE - x;
			x2 = (x * x) >> 30;
			p  = POLY_A3 - ((POLY_A5 * x2) >> 30);
			q  = POLY_A1 - ((x2 * p) >> 30);
			s  = (x * q) >> 30;
			if (s > Q30_ONE)
				s = Q30_ONE;
			amp = (s * AMP_MAX) >> 30;
			if (amp > AMP_MAX)
				amp = AMP_MAX;
			rom[k] = quad[1] ? SINE_W'(-amp) : SINE_W'(amp);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
		input logic signed [ACC_WIDTH:0] v
	);
		logic signed [ACC_WIDTH-1:0] r;
		if (v[ACC_WIDTH] != v[ACC_WIDTH-1])
			r = v[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
		else
			r = v[ACC_WIDTH-1:0];
		return r;
	endfunction

	function automatic logic signed [METRIC_W-1:0] sat_metric(
		input logic signed [METRIC_W:0] v
	);
		logic signed [METRIC_W-1:0] r;
		if (v[METRIC_W] != v[METRIC_W-1])
			r = v[METRIC_W] ? {1'b1, {(METRIC_W-1){1'b0}}} : {1'b0, {(METRIC_W-1){1'b1}}};
		else
			r = v[METRIC_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/ckd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ckd_if: sample and result channels
// Valid/ready channels carrying one word per handshake.
// ----------------------------------------------------------------------------
interface ckd_in_if;
	logic                                        valid;
	logic                                        ready;
	logic signed [ckd_pkg::SAMPLE_WIDTH-1:0]     rx_sample;

	modport source (output valid, output rx_sample, input ready);
	modport sink (input valid, input rx_sample, output ready);
endinterface

interface ckd_out_if;
	logic                                        valid;
	logic                                        ready;
	logic                                        sample_decision;
	logic                                        bit_valid;
	logic                                        bit_value;
	logic signed [ckd_pkg::METRIC_W-1:0]         decision_metric;

	modport source (output valid, output sample_decision, output bit_valid,
		output bit_value, output decision_metric, input ready);
	modport sink (input valid, input sample_decision, input bit_valid,
		input bit_value, input decision_metric, output ready);
endinterface
`default_nettype wire

// ----- design/ckd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ckd_front: sample intake, reference oscillators and bit position
// Advance both phase accumulators, look up the sines and tag each word.
// ----------------------------------------------------------------------------
module ckd_front (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire ckd_pkg::cfg_t                            cfg,
	ckd_in_if.sink                                        samples,
	output logic                                          valid_s1,
	input  wire logic                                     ready_dn,
	output logic signed [ckd_pkg::SAMPLE_WIDTH-1:0]       sample_s1,
	output logic signed [ckd_pkg::SINE_W-1:0]             sine_one_s1,
	output logic signed [ckd_pkg::SINE_W-1:0]             sine_two_s1,
	output ckd_pkg::tag_t                                 tag_s1
);

	logic [ckd_pkg::PHASE_WIDTH-1:0] phase_one_q;
	logic [ckd_pkg::PHASE_WIDTH-1:0] phase_two_q;
	logic [ckd_pkg::COUNT_W-1:0]     sample_in_bit_q;
	logic                            take;
	logic                            last;
	logic [ckd_pkg::ROM_ADDR_W-1:0]  addr_one;
	logic [ckd_pkg::ROM_ADDR_W-1:0]  addr_two;

	assign samples.ready = !valid_s1 || ready_dn;
	assign take          = samples.valid && samples.ready;
	assign last          = ({1'b0, sample_in_bit_q} + 17'd1) >= {1'b0, cfg.samples_per_bit};
	assign addr_one      = phase_one_q[ckd_pkg::PHASE_WIDTH-1 -: ckd_pkg::ROM_ADDR_W];
	assign addr_two      = phase_two_q[ckd_pkg::PHASE_WIDTH-1 -: ckd_pkg::ROM_ADDR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			phase_one_q     <= '0;
			phase_two_q     <= '0;
			sample_in_bit_q <= '0;
		end else begin
			if (samples.ready)
				valid_s1 <= samples.valid;
			if (take) begin
				phase_one_q <= phase_one_q + cfg.phase_inc_one;
				phase_two_q <= phase_two_q + cfg.phase_inc_two;
				sample_in_bit_q <= last ? '0 : sample_in_bit_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1    <= samples.rx_sample;
			sine_one_s1  <= ckd_pkg::SINE_ROM[addr_one];
			sine_two_s1  <= ckd_pkg::SINE_ROM[addr_two];
			tag_s1.first <= (sample_in_bit_q == '0);
			tag_s1.last  <= last;
		end
	end

endmodule
`default_nettype wire

// ----- design/ckd_mix.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ckd_mix: mixer stage
// Multiply the sample by both reference sines, Q1.15 by Q1.15 into Q2.30.
// ----------------------------------------------------------------------------
module ckd_mix (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     valid_s1,
	output logic                                          ready_s1,
	input  wire logic signed [ckd_pkg::SAMPLE_WIDTH-1:0]  sample_s1,
	input  wire logic signed [ckd_pkg::SINE_W-1:0]        sine_one_s1,
	input  wire logic signed [ckd_pkg::SINE_W-1:0]        sine_two_s1,
	input  wire ckd_pkg::tag_t                            tag_s1,
	output logic                                          valid_s2,
	input  wire logic                                     ready_dn,
	output logic signed [ckd_pkg::PROD_W-1:0]             prod_one_s2,
	output logic signed [ckd_pkg::PROD_W-1:0]             prod_two_s2,
	output ckd_pkg::tag_t                                 tag_s2
);

	logic take;

	assign ready_s1 = !valid_s2 || ready_dn;
	assign take     = valid_s1 && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			prod_one_s2 <= ckd_pkg::PROD_W'(sample_s1 * sine_one_s1);
			prod_two_s2 <= ckd_pkg::PROD_W'(sample_s1 * sine_two_s1);
			tag_s2      <= tag_s1;
		end
	end

endmodule
`default_nettype wire

// ----- design/ckd_integ.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ckd_integ: integrate and dump
// Two saturating integrators, then the saturating FSK difference sum.
// Each accumulator register doubles as the accumulator state and as its stage output.
// ----------------------------------------------------------------------------
module ckd_integ (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     valid_s2,
	output logic                                          ready_s2,
	input  wire logic signed [ckd_pkg::PROD_W-1:0]        prod_one_s2,
	input  wire logic signed [ckd_pkg::PROD_W-1:0]        prod_two_s2,
	input  wire ckd_pkg::tag_t                            tag_s2,
	output logic                                          valid_s4,
	input  wire logic                                     ready_dn,
	output logic signed [ckd_pkg::ACC_WIDTH-1:0]          integral_one_s4,
	output logic signed [ckd_pkg::METRIC_W-1:0]           running_sum_s4,
	output ckd_pkg::tag_t                                 tag_s4
);

	localparam int AW = ckd_pkg::ACC_WIDTH;
	localparam int MW = ckd_pkg::METRIC_W;

	logic                 valid_s3;
	logic                 ready_s3;
	logic                 take_s3;
	logic                 take_s4;
	logic signed [AW-1:0] integral_one_s3;
	logic signed [AW-1:0] integral_two_s3;
	ckd_pkg::tag_t        tag_s3;
	logic signed [AW-1:0] base_one;
	logic signed [AW-1:0] base_two;
	logic signed [AW:0]   sum_one;
	logic signed [AW:0]   sum_two;
	logic signed [AW:0]   diff;
	logic signed [MW-1:0] base_sum;
	logic signed [MW:0]   sum_run;

	assign ready_s2 = !valid_s3 || ready_s3;
	assign ready_s3 = !valid_s4 || ready_dn;
	assign take_s3  = valid_s2 && ready_s2;
	assign take_s4  = valid_s3 && ready_s3;

	// dump on the first sample of a bit
	assign base_one = tag_s2.first ? '0 : integral_one_s3;
	assign base_two = tag_s2.first ? '0 : integral_two_s3;
	assign sum_one  = (AW+1)'(base_one) + (AW+1)'(prod_one_s2);
	assign sum_two  = (AW+1)'(base_two) + (AW+1)'(prod_two_s2);

	assign diff     = (AW+1)'(integral_two_s3) - (AW+1)'(integral_one_s3);
	assign base_sum = tag_s3.first ? '0 : running_sum_s4;
	assign sum_run  = (MW+1)'(base_sum) + (MW+1)'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3        <= 1'b0;
			valid_s4        <= 1'b0;
			integral_one_s3 <= '0;
			integral_two_s3 <= '0;
			running_sum_s4  <= '0;
		end else begin
			if (ready_s2)
				valid_s3 <= valid_s2;
			if (ready_s3)
				valid_s4 <= valid_s3;
			if (take_s3) begin
				integral_one_s3 <= ckd_pkg::sat_acc(sum_one);
				integral_two_s3 <= ckd_pkg::sat_acc(sum_two);
			end
			if (take_s4)
				running_sum_s4 <= ckd_pkg::sat_metric(sum_run);
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3)
			tag_s3 <= tag_s2;
		if (take_s4) begin
			integral_one_s4 <= integral_one_s3;
			tag_s4          <= tag_s3;
		end
	end

endmodule
`default_nettype wire

// ----- design/ckd_decide.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ckd_decide: per-sample decision, ones count and result register
// Select metric by mode, count decisions over the bit, vote on the last one.
// ----------------------------------------------------------------------------
module ckd_decide (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire ckd_pkg::cfg_t                            cfg,
	input  wire logic                                     valid_s4,
	output logic                                          ready_s4,
	input  wire logic signed [ckd_pkg::ACC_WIDTH-1:0]     integral_one_s4,
	input  wire logic signed [ckd_pkg::METRIC_W-1:0]      running_sum_s4,
	input  wire ckd_pkg::tag_t                            tag_s4,
	ckd_out_if.source                                     results
);

	localparam int CW = ckd_pkg::COUNT_W;

	logic                                   valid_q;
	logic                                   take;
	logic                                   dec;
	logic signed [ckd_pkg::METRIC_W-1:0]    metric;
	logic [CW-1:0]                          ones_count_q;
	logic [CW-1:0]                          base_count;
	logic [CW-1:0]                          new_count;
	logic                                   dec_q;
	logic                                   bit_valid_q;
	logic                                   bit_value_q;
	logic signed [ckd_pkg::METRIC_W-1:0]    metric_q;

	assign ready_s4 = !valid_q || results.ready;
	assign take     = valid_s4 && ready_s4;

	always_comb begin
		unique case (cfg.mode)
			ckd_pkg::MODE_ASK: begin
				dec    = integral_one_s4 > cfg.ask_threshold;
				metric = ckd_pkg::METRIC_W'(integral_one_s4);
			end
			ckd_pkg::MODE_PSK: begin
				dec    = integral_one_s4 < 0;
				metric = ckd_pkg::METRIC_W'(integral_one_s4);
			end
			default: begin
				// FSK, and the unused code behaves the same
				dec    = running_sum_s4 > 0;
				metric = running_sum_s4;
			end
		endcase
	end

	// restart the count on the first sample; stop at full scale
	assign base_count = tag_s4.first ? '0 : ones_count_q;
	assign new_count  = (dec && base_count != '1) ? base_count + 16'd1 : base_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			ones_count_q <= '0;
		end else begin
			if (ready_s4)
				valid_q <= valid_s4;
			if (take)
				ones_count_q <= new_count;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dec_q       <= dec;
			bit_valid_q <= tag_s4.last;
			bit_value_q <= tag_s4.last && (new_count > cfg.ones_threshold);
			metric_q    <= metric;
		end
	end

	assign results.valid           = valid_q;
	assign results.sample_decision = dec_q;
	assign results.bit_valid       = bit_valid_q;
	assign results.bit_value       = bit_value_q;
	assign results.decision_metric = metric_q;

endmodule
`default_nettype wire

// ----- design/coherent_keyed_demodulator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// coherent_keyed_demodulator: coherent ASK / PSK / FSK integrate-and-dump
// Mixes each received sample with one or two table-driven reference sines,
// integrates over the bit period and votes the per-sample decisions.
// ----------------------------------------------------------------------------
//
//  channel   | dir | word                                      | accepted when
//  ----------+-----+-------------------------------------------+---------------
//  samples   | in  | rx_sample (Q1.15)                         | valid && ready
//  results   | out | sample_decision, bit_valid, bit_value,    | valid && ready
//            |     | decision_metric                           |
//  cfg       | in  | cfg_index, cfg_data                       | cfg_we
//
//  One word in and one word out per clock while the output is not stalled;
//  every sample passes five registers in order (sine lookup, mixer,
//  integrators, FSK sum, decision register) before its result word stands
//  on the output.
//  Each stage holds its own valid bit and loads whenever it is empty or its
//  successor moves on, so bubbles close up and a sample can still be taken
//  while a finished result waits on the output.
//  Reset clears the phase accumulators, bit position, integrators, FSK sum,
//  ones count and all valid bits, and loads the register defaults.
//
module coherent_keyed_demodulator (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	ckd_in_if.sink                                     samples,
	ckd_out_if.source                                  results,
	input  wire logic                                  cfg_we,
	input  wire logic [ckd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [ckd_pkg::CFG_DATA_W-1:0]        cfg_data
);

	ckd_pkg::cfg_t                           cfg_q;

	logic                                    valid_s1;
	logic                                    ready_s1;
	logic signed [ckd_pkg::SAMPLE_WIDTH-1:0] sample_s1;
	logic signed [ckd_pkg::SINE_W-1:0]       sine_one_s1;
	logic signed [ckd_pkg::SINE_W-1:0]       sine_two_s1;
	ckd_pkg::tag_t                           tag_s1;

	logic                                    valid_s2;
	logic                                    ready_s2;
	logic signed [ckd_pkg::PROD_W-1:0]       prod_one_s2;
	logic signed [ckd_pkg::PROD_W-1:0]       prod_two_s2;
	ckd_pkg::tag_t                           tag_s2;

	logic                                    valid_s4;
	logic                                    ready_s4;
	logic signed [ckd_pkg::ACC_WIDTH-1:0]    integral_one_s4;
	logic signed [ckd_pkg::METRIC_W-1:0]     running_sum_s4;
	ckd_pkg::tag_t                           tag_s4;

	// Register bank: the user writes only while the datapath is idle; the block
	// does not enforce it. Stages read these unshadowed. Unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= ckd_pkg::MODE_ASK;
			cfg_q.samples_per_bit <= 16'd1000;
			cfg_q.phase_inc_one   <= ckd_pkg::PHASE_WIDTH'(32'd4294967);
			cfg_q.phase_inc_two   <= ckd_pkg::PHASE_WIDTH'(32'd8589934);
			cfg_q.ask_threshold   <= '0;
			cfg_q.ones_threshold  <= 16'd500;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ckd_pkg::REG_MODE:     cfg_q.mode            <= cfg_data[1:0];
				ckd_pkg::REG_SPB:      cfg_q.samples_per_bit <= cfg_data[ckd_pkg::COUNT_W-1:0];
				ckd_pkg::REG_INC_ONE:  cfg_q.phase_inc_one   <= cfg_data[ckd_pkg::PHASE_WIDTH-1:0];
				ckd_pkg::REG_INC_TWO:  cfg_q.phase_inc_two   <= cfg_data[ckd_pkg::PHASE_WIDTH-1:0];
				ckd_pkg::REG_ASK_THR:  cfg_q.ask_threshold   <= cfg_data[ckd_pkg::THR_W-1:0];
				ckd_pkg::REG_ONES_THR: cfg_q.ones_threshold  <= cfg_data[ckd_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: advance the oscillators, fetch sines, mark first/last of bit
	ckd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.samples     (samples),
		.valid_s1    (valid_s1),
		.ready_dn    (ready_s1),
		.sample_s1   (sample_s1),
		.sine_one_s1 (sine_one_s1),
		.sine_two_s1 (sine_two_s1),
		.tag_s1      (tag_s1)
	);

	// Stage 2: mix with both references
	ckd_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.ready_s1    (ready_s1),
		.sample_s1   (sample_s1),
		.sine_one_s1 (sine_one_s1),
		.sine_two_s1 (sine_two_s1),
		.tag_s1      (tag_s1),
		.valid_s2    (valid_s2),
		.ready_dn    (ready_s2),
		.prod_one_s2 (prod_one_s2),
		.prod_two_s2 (prod_two_s2),
		.tag_s2      (tag_s2)
	);

	// Stages 3 and 4: integrate and dump, then the FSK difference sum
	ckd_integ u_integ (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s2        (valid_s2),
		.ready_s2        (ready_s2),
		.prod_one_s2     (prod_one_s2),
		.prod_two_s2     (prod_two_s2),
		.tag_s2          (tag_s2),
		.valid_s4        (valid_s4),
		.ready_dn        (ready_s4),
		.integral_one_s4 (integral_one_s4),
		.running_sum_s4  (running_sum_s4),
		.tag_s4          (tag_s4)
	);

	// Stage 5: decide, count ones, vote at the end of the bit
	ckd_decide u_decide (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.valid_s4        (valid_s4),
		.ready_s4        (ready_s4),
		.integral_one_s4 (integral_one_s4),
		.running_sum_s4  (running_sum_s4),
		.tag_s4          (tag_s4),
		.results         (results)
	);

endmodule
`default_nettype wire
